@@ rtl/core/tlsg_pkg.sv @@
// shared types and constants for the thick line span generator
package tlsg_pkg;

   localparam int COORD_BITS_DEF  = 16;
   localparam int RADIUS_BITS_DEF = 8;

   // imax = r*707/1000 + 1, taken as (r*IMAX_SCALE) >> IMAX_SHIFT, exact for r < 1000
   localparam int IMAX_SCALE = 46334;
   localparam int IMAX_SHIFT = 16;
   localparam int MUL_B_BITS = 16;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_NEXT = 1'b1;

   typedef enum logic [1:0] {
      T_IDLE,
      T_WALK,
      T_SEND
   } top_state_type;

   typedef enum logic [2:0] {
      W_IDLE,
      W_IMAX,
      W_SQMAX,
      W_STEP,
      W_CMP
   } walk_state_type;

   typedef enum logic [2:0] {
      PH_CENTRE,
      PH_TEST,
      PH_OUTER_LO,
      PH_OUTER_HI,
      PH_INNER_LO,
      PH_INNER_HI
   } phase_type;

   typedef enum logic [1:0] {
      DIR_NONE,
      DIR_UP,
      DIR_DOWN
   } dir_type;

   typedef struct packed {
      logic load;
      logic search;
   } walk_cmd_type;

   typedef struct packed {
      logic done;
      logic found;
   } walk_stat_type;

endpackage

@@ rtl/core/tlsg_walker.sv @@
// line walker and circle span sequencer around one shared multiplier
module tlsg_walker
   import tlsg_pkg::*;
#(
   parameter int COORD_BITS  = COORD_BITS_DEF,
   parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  walk_cmd_type           cmd,
   input  logic [COORD_BITS-1:0]  ld_x1,
   input  logic [COORD_BITS-1:0]  ld_y1,
   input  logic [COORD_BITS-1:0]  ld_x2,
   input  logic [COORD_BITS-1:0]  ld_y2,
   input  logic [RADIUS_BITS-1:0] ld_radius,
   output walk_stat_type          stat,
   output logic [COORD_BITS-1:0]  span_x,
   output logic [COORD_BITS-1:0]  span_y,
   output logic [RADIUS_BITS:0]   span_len
);

   localparam int SW = COORD_BITS + RADIUS_BITS + 1;
   localparam int MA = RADIUS_BITS + 1;
   localparam int PW = MA + MUL_B_BITS;
   localparam int QW = 2 * RADIUS_BITS;
   localparam int EW = COORD_BITS + 1;

   walk_state_type         state_ff, state_in;
   logic                   busy_ff, busy_in;
   walk_stat_type          stat_ff, stat_in;
   logic [COORD_BITS-1:0]  ccol_ff, ccol_in, crow_ff, crow_in;
   logic [COORD_BITS-1:0]  dcol_ff, dcol_in, drow_ff, drow_in;
   logic [COORD_BITS-1:0]  major_ff, major_in;
   dir_type                dircol_ff, dircol_in, dirrow_ff, dirrow_in;
   logic [EW-1:0]          cerr_ff, cerr_in, rerr_ff, rerr_in;
   logic [EW-1:0]          steps_ff, steps_in;
   logic [RADIUS_BITS:0]   idx_ff, idx_in;
   logic [RADIUS_BITS-1:0] half_ff, half_in;
   phase_type              phase_ff, phase_in;
   logic [RADIUS_BITS-1:0] radius_ff, radius_in;
   logic [RADIUS_BITS-1:0] imax_ff, imax_in;
   logic [QW-1:0]          sqmax_ff, sqmax_in;
   logic [QW-1:0]          isq_ff, isq_in;
   logic [COORD_BITS-1:0]  span_x_ff, span_x_in, span_y_ff, span_y_in;
   logic [RADIUS_BITS:0]   span_len_ff, span_len_in;

   logic [MA-1:0]          mul_a;
   logic [MUL_B_BITS-1:0]  mul_b;
   logic [PW-1:0]          prod;

   logic                   reject;
   logic [EW-1:0]          cerr_sum, rerr_sum, steps_dec;
   logic [SW-1:0]          cx_w, cy_w, r_w, i_w, h_w, sx_w, sy_w;
   logic [RADIUS_BITS:0]   step_len;
   logic [QW:0]            circ_sum;

   function automatic logic [COORD_BITS-1:0] move_coord(
      input logic [COORD_BITS-1:0] c,
      input dir_type               d
   );
      logic [COORD_BITS-1:0] res;
      case (d)
         DIR_UP:   res = c + COORD_BITS'(1);
         DIR_DOWN: res = c - COORD_BITS'(1);
         default:  res = c;
      endcase
      return res;
   endfunction

   // the one shared multiplier
   assign prod = PW'(mul_a) * PW'(mul_b);

   assign reject = (ld_radius == '0)
                || (SW'(ld_x1) < SW'(ld_radius)) || (SW'(ld_x2) < SW'(ld_radius))
                || (SW'(ld_y1) < SW'(ld_radius)) || (SW'(ld_y2) < SW'(ld_radius));

   assign cerr_sum  = cerr_ff + EW'(dcol_ff);
   assign rerr_sum  = rerr_ff + EW'(drow_ff);
   assign steps_dec = (steps_ff != '0) ? steps_ff - EW'(1) : steps_ff;

   assign cx_w = SW'(ccol_ff);
   assign cy_w = SW'(crow_ff);
   assign r_w  = SW'(radius_ff);
   assign i_w  = SW'(idx_ff);
   assign h_w  = SW'(half_ff);
   assign circ_sum = (QW + 1)'(isq_ff) + (QW + 1)'(prod[QW-1:0]);

   always_comb begin
      state_in    = state_ff;
      busy_in     = busy_ff;
      stat_in     = '0;
      ccol_in     = ccol_ff;
      crow_in     = crow_ff;
      dcol_in     = dcol_ff;
      drow_in     = drow_ff;
      major_in    = major_ff;
      dircol_in   = dircol_ff;
      dirrow_in   = dirrow_ff;
      cerr_in     = cerr_ff;
      rerr_in     = rerr_ff;
      steps_in    = steps_ff;
      idx_in      = idx_ff;
      half_in     = half_ff;
      phase_in    = phase_ff;
      radius_in   = radius_ff;
      imax_in     = imax_ff;
      sqmax_in    = sqmax_ff;
      isq_in      = isq_ff;
      span_x_in   = span_x_ff;
      span_y_in   = span_y_ff;
      span_len_in = span_len_ff;
      mul_a       = '0;
      mul_b       = '0;
      sx_w        = '0;
      sy_w        = '0;
      step_len    = '0;
      case (state_ff)
         W_IDLE: begin
            if (cmd.load) begin
               radius_in = ld_radius;
               busy_in   = !reject;
               ccol_in   = ld_x1;
               crow_in   = ld_y1;
               cerr_in   = '0;
               rerr_in   = '0;
               idx_in    = '0;
               half_in   = '0;
               phase_in  = PH_CENTRE;
               if (ld_x2 > ld_x1) begin
                  dcol_in = ld_x2 - ld_x1; dircol_in = DIR_UP;
               end else if (ld_x2 < ld_x1) begin
                  dcol_in = ld_x1 - ld_x2; dircol_in = DIR_DOWN;
               end else begin
                  dcol_in = '0; dircol_in = DIR_NONE;
               end
               if (ld_y2 > ld_y1) begin
                  drow_in = ld_y2 - ld_y1; dirrow_in = DIR_UP;
               end else if (ld_y2 < ld_y1) begin
                  drow_in = ld_y1 - ld_y2; dirrow_in = DIR_DOWN;
               end else begin
                  drow_in = '0; dirrow_in = DIR_NONE;
               end
               if (reject) begin
                  stat_in.done = 1'b1;
               end else begin
                  state_in = W_IMAX;
               end
            end else if (cmd.search) begin
               state_in = W_STEP;
            end
         end
         W_IMAX: begin
            mul_a    = MA'(radius_ff);
            mul_b    = MUL_B_BITS'(IMAX_SCALE);
            imax_in  = prod[IMAX_SHIFT +: RADIUS_BITS] + RADIUS_BITS'(1);
            major_in = (dcol_ff > drow_ff) ? dcol_ff : drow_ff;
            state_in = W_SQMAX;
         end
         W_SQMAX: begin
            mul_a    = MA'(radius_ff);
            mul_b    = MUL_B_BITS'(radius_ff);
            sqmax_in = prod[QW-1:0] + QW'(radius_ff >> 1);
            steps_in = EW'(major_ff) + EW'(2);
            state_in = W_STEP;
         end
         W_STEP: begin
            if (!busy_ff) begin
               stat_in.done = 1'b1;
               state_in     = W_IDLE;
            end else begin
               case (phase_ff)
                  PH_CENTRE: begin
                     sx_w     = cx_w - r_w;
                     sy_w     = cy_w;
                     step_len = (RADIUS_BITS + 1)'(radius_ff) << 1;
                     idx_in   = (RADIUS_BITS + 1)'(1);
                     half_in  = radius_ff;
                     phase_in = PH_TEST;
                  end
                  PH_TEST: begin
                     if (idx_ff > (RADIUS_BITS + 1)'(imax_ff)) begin
                        // move the brush centre one step along the line
                        if (cerr_sum > EW'(major_ff)) begin
                           cerr_in = cerr_sum - EW'(major_ff);
                           ccol_in = move_coord(ccol_ff, dircol_ff);
                        end else begin
                           cerr_in = cerr_sum;
                        end
                        if (rerr_sum > EW'(major_ff)) begin
                           rerr_in = rerr_sum - EW'(major_ff);
                           crow_in = move_coord(crow_ff, dirrow_ff);
                        end else begin
                           rerr_in = rerr_sum;
                        end
                        steps_in = steps_dec;
                        if (steps_dec == '0) begin
                           busy_in = 1'b0;
                        end
                        phase_in = PH_CENTRE;
                     end else begin
                        mul_a    = MA'(idx_ff);
                        mul_b    = MUL_B_BITS'(idx_ff);
                        isq_in   = prod[QW-1:0];
                        state_in = W_CMP;
                     end
                  end
                  PH_OUTER_LO: begin
                     sx_w     = cx_w - i_w + SW'(1);
                     sy_w     = cy_w + h_w;
                     step_len = (idx_ff - (RADIUS_BITS + 1)'(1)) << 1;
                     phase_in = PH_OUTER_HI;
                  end
                  PH_OUTER_HI: begin
                     sx_w     = cx_w - i_w + SW'(1);
                     sy_w     = cy_w - h_w;
                     step_len = (idx_ff - (RADIUS_BITS + 1)'(1)) << 1;
                     half_in  = half_ff - RADIUS_BITS'(1);
                     phase_in = PH_INNER_LO;
                  end
                  PH_INNER_LO: begin
                     sx_w     = cx_w - h_w;
                     sy_w     = cy_w + i_w;
                     step_len = (RADIUS_BITS + 1)'(half_ff) << 1;
                     phase_in = PH_INNER_HI;
                  end
                  default: begin
                     sx_w     = cx_w - h_w;
                     sy_w     = cy_w - i_w;
                     step_len = (RADIUS_BITS + 1)'(half_ff) << 1;
                     idx_in   = idx_ff + (RADIUS_BITS + 1)'(1);
                     phase_in = PH_TEST;
                  end
               endcase
               if (step_len != '0) begin
                  span_x_in     = sx_w[COORD_BITS-1:0];
                  span_y_in     = sy_w[COORD_BITS-1:0];
                  span_len_in   = step_len;
                  stat_in.done  = 1'b1;
                  stat_in.found = 1'b1;
                  state_in      = W_IDLE;
               end
            end
         end
         W_CMP: begin
            mul_a = MA'(half_ff);
            mul_b = MUL_B_BITS'(half_ff);
            if (circ_sum > (QW + 1)'(sqmax_ff)) begin
               if (half_ff > imax_ff) begin
                  phase_in = PH_OUTER_LO;
               end else begin
                  half_in  = half_ff - RADIUS_BITS'(1);
                  phase_in = PH_INNER_LO;
               end
            end else begin
               phase_in = PH_INNER_LO;
            end
            state_in = W_STEP;
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
         busy_ff  <= 1'b0;
         stat_ff  <= '0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         stat_ff  <= stat_in;
      end
   end

   always_ff @(posedge clock) begin
      ccol_ff     <= ccol_in;
      crow_ff     <= crow_in;
      dcol_ff     <= dcol_in;
      drow_ff     <= drow_in;
      major_ff    <= major_in;
      dircol_ff   <= dircol_in;
      dirrow_ff   <= dirrow_in;
      cerr_ff     <= cerr_in;
      rerr_ff     <= rerr_in;
      steps_ff    <= steps_in;
      idx_ff      <= idx_in;
      half_ff     <= half_in;
      phase_ff    <= phase_in;
      radius_ff   <= radius_in;
      imax_ff     <= imax_in;
      sqmax_ff    <= sqmax_in;
      isq_ff      <= isq_in;
      span_x_ff   <= span_x_in;
      span_y_ff   <= span_y_in;
      span_len_ff <= span_len_in;
   end

   assign stat     = stat_ff;
   assign span_x   = span_x_ff;
   assign span_y   = span_y_ff;
   assign span_len = span_len_ff;

   a_cmp_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == W_CMP |-> idx_ff <= (RADIUS_BITS + 1)'(imax_ff))
      else $error("circle row index past imax at the compare step");

   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.search && state_ff == W_IDLE) |-> busy_ff)
      else $error("search started on a finished command");

   a_found_len: assert property (@(posedge clock) disable iff (reset)
      (stat_ff.done && stat_ff.found) |-> span_len_ff != '0)
      else $error("found span with zero length");

endmodule

@@ rtl/core/thick_line_span_generator_unit.sv @@
// top level of the thick line span generator
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | mode, end points, brush radius, colour
//  rsp     | out       | rsp_valid/rsp_stall | span x, y, length, colour, last
//
// load: imax and sqmax set-up, then its first search; next: a search and the send
// a search steps through the circle phases, the row tests on the shared multiplier and
// the brush steps; the output register load waits while rsp_stall holds a response
// reset needs no clearing pass; the block is ready for a request once reset falls
// a request is taken while a response still waits under rsp_stall
// the block stalls requests while its walker searches or a finished span waits
module thick_line_span_generator_unit
   import tlsg_pkg::*;
#(
   parameter int COORD_BITS  = COORD_BITS_DEF,
   parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [15:0] req_x_start,
   input  logic [15:0] req_y_start,
   input  logic [15:0] req_x_end,
   input  logic [15:0] req_y_end,
   input  logic [7:0]  req_brush_radius,
   input  logic [15:0] req_colour,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_span_x,
   output logic [15:0] rsp_span_y,
   output logic [8:0]  rsp_span_length,
   output logic [15:0] rsp_span_colour,
   output logic        rsp_last
);

   top_state_type          state_ff, state_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic                   emit_ff, emit_in;
   logic [15:0]            colour_ff, colour_in;
   logic [COORD_BITS-1:0]  cand_x_ff, cand_x_in, cand_y_ff, cand_y_in;
   logic [RADIUS_BITS:0]   cand_len_ff, cand_len_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [15:0]            rsp_span_x_ff, rsp_span_x_in;
   logic [15:0]            rsp_span_y_ff, rsp_span_y_in;
   logic [8:0]             rsp_span_length_ff, rsp_span_length_in;
   logic [15:0]            rsp_span_colour_ff, rsp_span_colour_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   req_accept;
   logic                   send_go;
   walk_cmd_type           cmd;
   walk_stat_type          stat;
   logic [COORD_BITS-1:0]  w_span_x, w_span_y;
   logic [RADIUS_BITS:0]   w_span_len;

   tlsg_walker #(
      .COORD_BITS  (COORD_BITS),
      .RADIUS_BITS (RADIUS_BITS)
   ) u_walker (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .ld_x1     (req_x_start[COORD_BITS-1:0]),
      .ld_y1     (req_y_start[COORD_BITS-1:0]),
      .ld_x2     (req_x_end[COORD_BITS-1:0]),
      .ld_y2     (req_y_end[COORD_BITS-1:0]),
      .ld_radius (req_brush_radius[RADIUS_BITS-1:0]),
      .stat      (stat),
      .span_x    (w_span_x),
      .span_y    (w_span_y),
      .span_len  (w_span_len)
   );

   assign req_stall  = (state_ff != T_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign send_go    = (state_ff == T_SEND) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in           = state_ff;
      pend_valid_in      = pend_valid_ff;
      emit_in            = emit_ff;
      colour_in          = colour_ff;
      cand_x_in          = cand_x_ff;
      cand_y_in          = cand_y_ff;
      cand_len_in        = cand_len_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_span_x_in      = rsp_span_x_ff;
      rsp_span_y_in      = rsp_span_y_ff;
      rsp_span_length_in = rsp_span_length_ff;
      rsp_span_colour_in = rsp_span_colour_ff;
      rsp_last_in        = rsp_last_ff;
      cmd                = '0;
      case (state_ff)
         T_IDLE: begin
            if (req_accept) begin
               if (req_mode == MODE_LOAD) begin
                  colour_in     = req_colour;
                  pend_valid_in = 1'b0;
                  emit_in       = 1'b0;
                  cmd.load      = 1'b1;
                  state_in      = T_WALK;
               end else if (pend_valid_ff) begin
                  // the span found ahead goes out once the one after it is known
                  cand_x_in   = w_span_x;
                  cand_y_in   = w_span_y;
                  cand_len_in = w_span_len;
                  emit_in     = 1'b1;
                  cmd.search  = 1'b1;
                  state_in    = T_WALK;
               end
            end
         end
         T_WALK: begin
            if (stat.done) begin
               pend_valid_in = stat.found;
               state_in      = emit_ff ? T_SEND : T_IDLE;
            end
         end
         T_SEND: begin
            if (send_go) begin
               rsp_valid_in       = 1'b1;
               rsp_span_x_in      = 16'(cand_x_ff);
               rsp_span_y_in      = 16'(cand_y_ff);
               rsp_span_length_in = 9'(cand_len_ff);
               rsp_span_colour_in = colour_ff;
               rsp_last_in        = !pend_valid_ff;
               state_in           = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= T_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      emit_ff            <= emit_in;
      colour_ff          <= colour_in;
      cand_x_ff          <= cand_x_in;
      cand_y_ff          <= cand_y_in;
      cand_len_ff        <= cand_len_in;
      rsp_span_x_ff      <= rsp_span_x_in;
      rsp_span_y_ff      <= rsp_span_y_in;
      rsp_span_length_ff <= rsp_span_length_in;
      rsp_span_colour_ff <= rsp_span_colour_in;
      rsp_last_ff        <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_span_x      = rsp_span_x_ff;
   assign rsp_span_y      = rsp_span_y_ff;
   assign rsp_span_length = rsp_span_length_ff;
   assign rsp_span_colour = rsp_span_colour_ff;
   assign rsp_last        = rsp_last_ff;

   a_done_in_walk: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> state_ff == T_WALK)
      else $error("walker finished outside of a walk");

   a_next_when_idle: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_mode == MODE_NEXT && !pend_valid_ff) |=> state_ff == T_IDLE)
      else $error("next request on a finished command started work");

   a_rsp_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_span_length_ff != '0)
      else $error("response with zero span length");

endmodule
